// ===== sv/wfm_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the windowed FFT magnitude block.
// No dependencies.
package wfm_pkg;

  localparam int MAX_POINTS  = 128;
  localparam int PTR_W       = 7;
  localparam int CNT_W       = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int WORK_BITS   = 24;
  localparam int BITS_W      = 3;

  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = 57;

  localparam int SQ_IN_W  = 48;
  localparam int SQ_OUT_W = 24;

  localparam int DIV_N_W = 18;
  localparam int DIV_D_W = 8;

  localparam logic [30:0] SIN_C1  = 31'd1686629713;
  localparam logic [30:0] SIN_C3  = 31'd693598668;
  localparam logic [30:0] SIN_C5  = 31'd85569299;
  localparam logic [30:0] SIN_C7  = 31'd5026996;
  localparam logic [30:0] SIN_C9  = 31'd172272;
  localparam logic [30:0] SIN_C11 = 31'd3864;

  typedef struct packed {
    logic signed [WORK_BITS-1:0] re;
    logic signed [WORK_BITS-1:0] im;
  } work_t;

  typedef struct packed {
    logic [DIV_N_W-1:0] quo;
    logic [DIV_D_W-1:0] rem;
  } div_res_t;

  // Horner coefficient for step hk (C9 down to C1)
  function automatic logic [30:0] sin_coef(input logic [2:0] hk);
    logic [30:0] c;
    case (hk)
      3'd0: c = SIN_C9;
      3'd1: c = SIN_C7;
      3'd2: c = SIN_C5;
      3'd3: c = SIN_C3;
      3'd4: c = SIN_C1;
      default: c = '0;
    endcase
    return c;
  endfunction

  // log2 of the transform size for a frame of m samples (m >= 2)
  function automatic logic [BITS_W-1:0] frame_bits(input logic [CNT_W-1:0] m);
    logic [CNT_W-1:0] mm;
    logic [BITS_W-1:0] res;
    mm  = m - 8'd1;
    res = '0;
    for (int b = 0; b < PTR_W; b++) begin
      if (mm[b]) res = BITS_W'(b + 1);
    end
    return res;
  endfunction

  function automatic logic [PTR_W-1:0] bit_rev(input logic [PTR_W-1:0] i,
                                               input logic [BITS_W-1:0] bits);
    logic [PTR_W-1:0] r;
    for (int b = 0; b < PTR_W; b++) begin
      r[b] = i[PTR_W-1-b];
    end
    return r >> (3'd7 - bits);
  endfunction

  function automatic logic signed [WORK_BITS-1:0] sat_work(input logic signed [27:0] v);
    logic signed [WORK_BITS-1:0] r;
    if (v > 28'sd8388607) r = 24'sh7FFFFF;
    else if (v < -28'sd8388608) r = 24'sh800000;
    else r = v[WORK_BITS-1:0];
    return r;
  endfunction

endpackage

// ===== sv/wfm_mul.sv =====
`timescale 1ns / 1ps
// Shared signed multiplier with registered product.
// Uses wfm_pkg.
module wfm_mul (
  input  logic                                  clk,
  input  logic signed [wfm_pkg::MUL_A_W-1:0]    a,
  input  logic signed [wfm_pkg::MUL_B_W-1:0]    b,
  output logic signed [wfm_pkg::MUL_P_W-1:0]    prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= wfm_pkg::MUL_P_W'(a) * wfm_pkg::MUL_P_W'(b);
  end

endmodule

// ===== sv/wfm_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Uses wfm_pkg.
module wfm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wfm_pkg::DIV_N_W-1:0]   num,
  input  logic [wfm_pkg::DIV_D_W-1:0]   den,
  output logic                          done_r,
  output wfm_pkg::div_res_t             res
);

  logic [wfm_pkg::DIV_N_W-1:0] n_r;
  logic [wfm_pkg::DIV_D_W-1:0] d_r;
  logic [wfm_pkg::DIV_D_W-1:0] rem_r;
  logic [4:0]                  cnt_r;
  logic                        busy_r;
  logic [wfm_pkg::DIV_D_W:0]   rt;
  logic                        qb;

  assign rt = {rem_r, n_r[wfm_pkg::DIV_N_W-1]};
  assign qb = (rt >= {1'b0, d_r});
  assign res.quo = n_r;
  assign res.rem = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        n_r    <= num;
        d_r    <= den;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= qb ? wfm_pkg::DIV_D_W'(rt - {1'b0, d_r}) : rt[wfm_pkg::DIV_D_W-1:0];
        n_r   <= {n_r[wfm_pkg::DIV_N_W-2:0], qb};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(wfm_pkg::DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/wfm_isqrt.sv =====
`timescale 1ns / 1ps
// Integer square root, two radicand bits per cycle.
// Uses wfm_pkg.
module wfm_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wfm_pkg::SQ_IN_W-1:0]   op,
  output logic                          done_r,
  output logic [wfm_pkg::SQ_OUT_W-1:0]  root_r
);

  logic [wfm_pkg::SQ_IN_W-1:0] op_r;
  logic [26:0]                 rem_r;
  logic [26:0]                 rt;
  logic [26:0]                 trial;
  logic [4:0]                  cnt_r;
  logic                        busy_r;

  assign rt    = {rem_r[24:0], op_r[wfm_pkg::SQ_IN_W-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        op_r   <= op;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        op_r <= op_r << 2;
        if (rt >= trial) begin
          rem_r  <= rt - trial;
          root_r <= {root_r[wfm_pkg::SQ_OUT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rt;
          root_r <= {root_r[wfm_pkg::SQ_OUT_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(wfm_pkg::SQ_OUT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/windowed_fft_magnitude_spectrum.sv =====
`timescale 1ns / 1ps
// Top level: sample ring, work memory, sequencer for window, FFT and magnitude.
// Uses wfm_pkg, wfm_mul, wfm_div, wfm_isqrt.
//
// Samples are taken one per cycle while idle; a request with last set starts
// the transform of the kept frame (M samples, n = next power of two up to 128),
// and in_stall stays high until the last bin is taken. All multiplications run
// through one registered multiplier, shared by the sine/cosine evaluation, the
// window, the butterflies and the bin magnitudes; setup divides in wfm_div and
// each bin root comes from wfm_isqrt. A frame of one sample gives no bins and
// no stall.
module windowed_fft_magnitude_spectrum (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [wfm_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [5:0]                          out_bin_index,
  output logic [15:0]                         out_magnitude,
  output logic                                out_last_bin
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DIV   = 5'd1;
  localparam logic [4:0] S_WIN   = 5'd2;
  localparam logic [4:0] S_WMUL  = 5'd3;
  localparam logic [4:0] S_WWR   = 5'd4;
  localparam logic [4:0] S_BF0   = 5'd5;
  localparam logic [4:0] S_BF1   = 5'd6;
  localparam logic [4:0] S_BF2   = 5'd7;
  localparam logic [4:0] S_BF3   = 5'd8;
  localparam logic [4:0] S_BF4   = 5'd9;
  localparam logic [4:0] S_BF5   = 5'd10;
  localparam logic [4:0] S_BF6   = 5'd11;
  localparam logic [4:0] S_BF7   = 5'd12;
  localparam logic [4:0] S_BF8   = 5'd13;
  localparam logic [4:0] S_BF9   = 5'd14;
  localparam logic [4:0] S_BF10  = 5'd15;
  localparam logic [4:0] S_M0    = 5'd16;
  localparam logic [4:0] S_M1    = 5'd17;
  localparam logic [4:0] S_M2    = 5'd18;
  localparam logic [4:0] S_M3    = 5'd19;
  localparam logic [4:0] S_M4    = 5'd20;
  localparam logic [4:0] S_OUT   = 5'd21;
  localparam logic [4:0] T_START = 5'd22;
  localparam logic [4:0] T_Z2    = 5'd23;
  localparam logic [4:0] T_HMUL  = 5'd24;
  localparam logic [4:0] T_HSUB  = 5'd25;
  localparam logic [4:0] T_LAST  = 5'd26;
  localparam logic [4:0] T_FIN   = 5'd27;

  logic [4:0] state_r, ret_r;

  logic [wfm_pkg::PTR_W-1:0]  wp_r, start_r, i_r, ring_ra;
  logic [wfm_pkg::CNT_W-1:0]  kept_r, kept_nxt, m_r;
  logic [wfm_pkg::BITS_W-1:0] bits_r, stage_r;
  logic [16:0] q_r, q0_r;
  logic [7:0]  r_r, r0_r;
  logic [5:0]  k_r;
  logic        in_acc;

  logic [15:0]        ph_r;
  logic [14:0]        z_r, z2_r, z_c;
  logic [1:0]         quad_r;
  logic [30:0]        acc_r;
  logic [2:0]         hk_r;
  logic signed [16:0] trig_r, c_r, s_r;
  logic [16:0]        tmag;
  logic [17:0]        wsum;
  logic [15:0]        w_c;

  wfm_pkg::work_t     xa_r, xb_r, work_q_r, work_wd;
  logic signed [wfm_pkg::MUL_P_W-1:0] p1_r, prod, xs, tsum;
  logic signed [26:0] tr_r, ti_r;

  logic signed [wfm_pkg::MUL_A_W-1:0] mul_a;
  logic signed [wfm_pkg::MUL_B_W-1:0] mul_b;

  logic [wfm_pkg::PTR_W-1:0] nmask, hm, kk, a_addr, b_addr, work_ra, work_wa, jj;
  logic [5:0]  hmask;
  logic [15:0] tw_ph;
  logic        ring_re, work_re, work_we, in_frame;

  logic        div_start, div_done;
  wfm_pkg::div_res_t div_res;
  logic        sq_start, sq_done;
  logic [wfm_pkg::SQ_IN_W-1:0]  sq_op;
  logic [wfm_pkg::SQ_OUT_W-1:0] sq_root;
  logic [25:0] mag_c;

  logic [wfm_pkg::SAMPLE_BITS-1:0] ring [wfm_pkg::MAX_POINTS];
  logic [wfm_pkg::SAMPLE_BITS-1:0] ring_q_r;
  wfm_pkg::work_t work_mem [wfm_pkg::MAX_POINTS];

  logic        out_valid_r, out_last_r;
  logic [5:0]  out_idx_r;
  logic [15:0] out_mag_r;

  assign in_stall      = (state_r != S_IDLE);
  assign in_acc        = in_valid && !in_stall;
  assign out_valid     = out_valid_r;
  assign out_bin_index = out_idx_r;
  assign out_magnitude = out_mag_r;
  assign out_last_bin  = out_last_r;

  assign kept_nxt = (kept_r == 8'(wfm_pkg::MAX_POINTS)) ? kept_r : kept_r + 8'd1;
  assign nmask    = 7'((8'd1 << bits_r) - 8'd1);
  assign hmask    = nmask[6:1];
  assign hm       = 7'((8'd1 << (stage_r - 3'd1)) - 8'd1);
  assign kk       = {1'b0, k_r};
  assign a_addr   = ((kk & ~hm) << 1) | (kk & hm);
  assign b_addr   = a_addr | (hm + 7'd1);
  assign jj       = kk & hm;
  assign tw_ph    = 16'({9'b0, jj} << (5'd16 - {2'b0, stage_r}));
  assign in_frame = ({1'b0, i_r} < m_r);
  assign ring_ra  = start_r + i_r;

  assign z_c  = ph_r[14] ? 15'(15'd16384 - {1'b0, ph_r[13:0]}) : {1'b0, ph_r[13:0]};
  assign wsum = 18'sd32768 - {trig_r[16], trig_r};
  assign w_c  = wsum[16:1];
  assign tmag = 17'(((prod >>> 14) + 57'sd16384) >>> 15);
  assign xs   = (prod + 57'sd16384) >>> 15;
  assign mag_c = (26'({sq_root, 1'b0}) + 26'(hmask) + 26'd1) >> bits_r;
  assign tsum = p1_r + prod;

  wfm_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_r(prod));

  wfm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(18'd131072),
    .den(8'((kept_nxt - 8'd1) << 1)), .done_r(div_done), .res(div_res)
  );

  wfm_isqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .op(sq_op),
    .done_r(sq_done), .root_r(sq_root)
  );

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    ring_re   = 1'b0;
    work_re   = 1'b0;
    work_ra   = i_r;
    work_we   = 1'b0;
    work_wa   = wfm_pkg::bit_rev(i_r, bits_r);
    work_wd   = '0;
    sq_start  = 1'b0;
    sq_op     = 48'(p1_r + prod);
    div_start = in_acc && in_last && (kept_nxt >= 8'd2);
    case (state_r)
      T_START: begin
        mul_a = {17'b0, z_c};
        mul_b = {10'b0, z_c};
      end
      T_HMUL: begin
        mul_a = {1'b0, acc_r};
        mul_b = {10'b0, z2_r};
      end
      T_LAST: begin
        mul_a = {1'b0, acc_r};
        mul_b = {10'b0, z_r};
      end
      S_WIN: begin
        ring_re = in_frame;
        work_we = !in_frame;
      end
      S_WMUL: begin
        mul_a = {{16{ring_q_r[15]}}, ring_q_r};
        mul_b = {9'b0, w_c};
      end
      S_WWR: begin
        work_we    = 1'b1;
        work_wd.re = xs[23:0];
      end
      S_BF2: begin
        work_re = 1'b1;
        work_ra = b_addr;
      end
      S_BF3: begin
        work_re = 1'b1;
        work_ra = a_addr;
      end
      S_BF4: begin
        mul_a = {{8{xb_r.re[23]}}, xb_r.re};
        mul_b = {{8{c_r[16]}}, c_r};
      end
      S_BF5: begin
        mul_a = {{8{xb_r.im[23]}}, xb_r.im};
        mul_b = {{8{s_r[16]}}, s_r};
      end
      S_BF6: begin
        mul_a = {{8{xb_r.im[23]}}, xb_r.im};
        mul_b = {{8{c_r[16]}}, c_r};
      end
      S_BF7: begin
        mul_a = {{8{xb_r.re[23]}}, xb_r.re};
        mul_b = {{8{s_r[16]}}, s_r};
      end
      S_BF9: begin
        work_we    = 1'b1;
        work_wa    = a_addr;
        work_wd.re = wfm_pkg::sat_work({{4{xa_r.re[23]}}, xa_r.re} + {tr_r[26], tr_r});
        work_wd.im = wfm_pkg::sat_work({{4{xa_r.im[23]}}, xa_r.im} + {ti_r[26], ti_r});
      end
      S_BF10: begin
        work_we    = 1'b1;
        work_wa    = b_addr;
        work_wd.re = wfm_pkg::sat_work({{4{xa_r.re[23]}}, xa_r.re} - {tr_r[26], tr_r});
        work_wd.im = wfm_pkg::sat_work({{4{xa_r.im[23]}}, xa_r.im} - {ti_r[26], ti_r});
      end
      S_M0: begin
        work_re = 1'b1;
      end
      S_M1: begin
        mul_a = {{8{work_q_r.re[23]}}, work_q_r.re};
        mul_b = {work_q_r.re[23], work_q_r.re};
      end
      S_M2: begin
        mul_a = {{8{xb_r.im[23]}}, xb_r.im};
        mul_b = {xb_r.im[23], xb_r.im};
      end
      S_M3: begin
        sq_start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) ring[wp_r] <= in_sample;
    if (ring_re) ring_q_r <= ring[ring_ra];
    if (work_we) work_mem[work_wa] <= work_wd;
    if (work_re) work_q_r <= work_mem[work_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      kept_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            wp_r <= wp_r + 7'd1;
            if (in_last) begin
              kept_r  <= '0;
              m_r     <= kept_nxt;
              bits_r  <= wfm_pkg::frame_bits(kept_nxt);
              start_r <= wp_r + 7'd1 - kept_nxt[6:0];
              if (kept_nxt >= 8'd2) state_r <= S_DIV;
            end else begin
              kept_r <= kept_nxt;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            q0_r    <= div_res.quo[16:0];
            r0_r    <= div_res.rem;
            q_r     <= '0;
            r_r     <= m_r - 8'd1;
            i_r     <= '0;
            state_r <= S_WIN;
          end
        end
        S_WIN, S_WWR: begin
          if (state_r == S_WIN && in_frame) begin
            ph_r    <= q_r[15:0] + 16'd16384;
            ret_r   <= S_WMUL;
            state_r <= T_START;
          end else begin
            if (({1'b0, r_r} + {1'b0, r0_r}) >= 9'((m_r - 8'd1) << 1)) begin
              r_r <= 8'(({1'b0, r_r} + {1'b0, r0_r}) - 9'((m_r - 8'd1) << 1));
              q_r <= q_r + q0_r + 17'd1;
            end else begin
              r_r <= r_r + r0_r;
              q_r <= q_r + q0_r;
            end
            i_r <= i_r + 7'd1;
            if (i_r == nmask) begin
              stage_r <= 3'd1;
              k_r     <= '0;
              state_r <= S_BF0;
            end else begin
              state_r <= S_WIN;
            end
          end
        end
        S_WMUL: state_r <= S_WWR;
        T_START: begin
          z_r     <= z_c;
          quad_r  <= ph_r[15:14];
          state_r <= T_Z2;
        end
        T_Z2: begin
          z2_r    <= 15'(prod >>> 14);
          acc_r   <= wfm_pkg::SIN_C11;
          hk_r    <= '0;
          state_r <= T_HMUL;
        end
        T_HMUL: state_r <= T_HSUB;
        T_HSUB: begin
          acc_r   <= 31'(wfm_pkg::sin_coef(hk_r) - 31'(prod >>> 14));
          hk_r    <= hk_r + 3'd1;
          state_r <= (hk_r == 3'd4) ? T_LAST : T_HMUL;
        end
        T_LAST: state_r <= T_FIN;
        T_FIN: begin
          if (quad_r[1]) trig_r <= -$signed((tmag > 17'd32768) ? 17'd32768 : tmag);
          else trig_r <= $signed((tmag > 17'd32768) ? 17'd32768 : tmag);
          state_r <= ret_r;
        end
        S_BF0: begin
          ph_r    <= tw_ph + 16'd16384;
          ret_r   <= S_BF1;
          state_r <= T_START;
        end
        S_BF1: begin
          c_r     <= trig_r;
          ph_r    <= tw_ph;
          ret_r   <= S_BF2;
          state_r <= T_START;
        end
        S_BF2: begin
          s_r     <= trig_r;
          state_r <= S_BF3;
        end
        S_BF3: begin
          xb_r    <= work_q_r;
          state_r <= S_BF4;
        end
        S_BF4: begin
          xa_r    <= work_q_r;
          state_r <= S_BF5;
        end
        S_BF5: begin
          p1_r    <= prod;
          state_r <= S_BF6;
        end
        S_BF6: begin
          tr_r    <= 27'((tsum + 57'sd16384) >>> 15);
          state_r <= S_BF7;
        end
        S_BF7: begin
          p1_r    <= prod;
          state_r <= S_BF8;
        end
        S_BF8: begin
          ti_r    <= 27'((p1_r - prod + 57'sd16384) >>> 15);
          state_r <= S_BF9;
        end
        S_BF9: state_r <= S_BF10;
        S_BF10: begin
          if (k_r == hmask) begin
            k_r <= '0;
            if (stage_r == bits_r) begin
              i_r     <= '0;
              state_r <= S_M0;
            end else begin
              stage_r <= stage_r + 3'd1;
              state_r <= S_BF0;
            end
          end else begin
            k_r     <= k_r + 6'd1;
            state_r <= S_BF0;
          end
        end
        S_M0: state_r <= S_M1;
        S_M1: begin
          xb_r    <= work_q_r;
          state_r <= S_M2;
        end
        S_M2: begin
          p1_r    <= prod;
          state_r <= S_M3;
        end
        S_M3: state_r <= S_M4;
        S_M4: begin
          if (sq_done) begin
            out_idx_r   <= i_r[5:0];
            out_mag_r   <= (mag_c > 26'd65535) ? 16'hFFFF : mag_c[15:0];
            out_last_r  <= (i_r[5:0] == hmask);
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (i_r[5:0] == hmask) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + 7'd1;
              state_r <= S_M0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("result pending while input is open");
  a_last_bin_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_bin) |-> (out_bin_index == hmask))
    else $error("last bin flag on wrong bin");
  a_sqrt_start: assert property (@(posedge clk) disable iff (!rst_n)
    sq_start |=> (state_r == S_M4))
    else $error("sqrt started outside magnitude step");
`endif

endmodule
